// File: src/socket_open_retry_fsm_core_defines.svh
// Assertion macros shared by the socket open retry sequencer RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SOCKET_OPEN_RETRY_FSM_CORE_DEFINES_SVH
`define SOCKET_OPEN_RETRY_FSM_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define SORF_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication violated");
// Next-cycle implication.
`define SORF_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication violated");
`else
`define SORF_ASSERT_IMPL(label, clk, rst, pre, post)
`define SORF_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

// File: src/sorf_pkg.sv
// Types, codes and helpers for the socket open retry sequencer.
// No dependencies; imported by every module of the block.
package sorf_pkg;

   localparam int CntWidth = 8;

   localparam logic [CntWidth-1:0] CloseWaitReset    = 8'd30;
   localparam logic [CntWidth-1:0] PollIntervalReset = 8'd5;
   localparam logic [CntWidth-1:0] PollCountReset    = 8'd6;
   localparam logic [CntWidth-1:0] OpenAttemptsReset = 8'd3;

   // Register indexes on the configuration port.
   typedef enum logic [1:0] {
      REG_CLOSE_WAIT    = 2'd0,
      REG_POLL_INTERVAL = 2'd1,
      REG_POLL_COUNT    = 2'd2,
      REG_OPEN_ATTEMPTS = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_CLOSE   = 3'd1,
      ACT_WAIT    = 3'd2,
      ACT_OPEN    = 3'd3,
      ACT_EVAL    = 3'd4,
      ACT_OFF     = 3'd5,
      ACT_STANDBY = 3'd6,
      ACT_RELOAD  = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      S_CLOSE       = 3'd0,
      S_CLOSE_WAIT  = 3'd1,
      S_CLOSE_CHECK = 3'd2,
      S_OPEN        = 3'd3,
      S_POLL        = 3'd4,
      S_CHECK       = 3'd5,
      S_NEXT_POLL   = 3'd6,
      S_RETRY       = 3'd7
   } state_type;

   typedef enum logic [1:0] {
      RC_NONE      = 2'd0,
      RC_CONNECTED = 2'd1,
      RC_ERROR     = 2'd2
   } resp_code_type;

   typedef enum logic [1:0] {
      SU_NONE   = 2'd0,
      SU_OPEN   = 2'd1,
      SU_CLOSED = 2'd2
   } sock_upd_type;

   typedef struct packed {
      logic [CntWidth-1:0] close_wait;
      logic [CntWidth-1:0] poll_interval;
      logic [CntWidth-1:0] poll_count;
      logic [CntWidth-1:0] open_attempts;
   } cfg_type;

   typedef struct packed {
      logic reload_pending;
      logic error_seen;
      logic connect_seen;
      logic response_was_error;
      logic socket_is_open;
   } item_type;

   typedef struct packed {
      sock_upd_type  socket_update;
      resp_code_type response_code;
      state_type     next_substate;
      action_type    action;
   } result_type;

   function automatic logic [CntWidth-1:0] dec_sat(input logic [CntWidth-1:0] v);
      return (v == '0) ? '0 : v - 1'b1;
   endfunction

endpackage

// File: src/sorf_csr.sv
// Configuration register file of the socket open retry sequencer (APB-style).
// Depends on sorf_pkg for register indexes, reset values and cfg_type.
module sorf_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output sorf_pkg::cfg_type    cfg
);
   import sorf_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[3:2]);
   assign wr_en  = psel & penable & pwrite & pready;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_CLOSE_WAIT:    cfg_in.close_wait    = pwdata[CntWidth-1:0];
            REG_POLL_INTERVAL: cfg_in.poll_interval = pwdata[CntWidth-1:0];
            REG_POLL_COUNT:    cfg_in.poll_count    = pwdata[CntWidth-1:0];
            REG_OPEN_ATTEMPTS: cfg_in.open_attempts = pwdata[CntWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         REG_CLOSE_WAIT:    prdata[CntWidth-1:0] = cfg_ff.close_wait;
         REG_POLL_INTERVAL: prdata[CntWidth-1:0] = cfg_ff.poll_interval;
         REG_POLL_COUNT:    prdata[CntWidth-1:0] = cfg_ff.poll_count;
         REG_OPEN_ATTEMPTS: prdata[CntWidth-1:0] = cfg_ff.open_attempts;
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.close_wait    <= CloseWaitReset;
         cfg_ff.poll_interval <= PollIntervalReset;
         cfg_ff.poll_count    <= PollCountReset;
         cfg_ff.open_attempts <= OpenAttemptsReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/sorf_step.sv
// Sequencer state machine and its counters; computes one step per enable.
// Depends on sorf_pkg for the state, action and result types.
module sorf_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  sorf_pkg::item_type    item,
   input  sorf_pkg::cfg_type     cfg,
   output sorf_pkg::result_type  result
);
   import sorf_pkg::*;

   state_type           state_ff, state_in;
   logic [CntWidth-1:0] countdown_ff, countdown_in;
   logic [CntWidth-1:0] polls_ff, polls_in;
   logic [CntWidth-1:0] attempts_ff, attempts_in;
   action_type          action;
   resp_code_type       rcode;
   sock_upd_type        supd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLOSE;
         countdown_ff <= '0;
         polls_ff     <= '0;
         attempts_ff  <= '0;
      end else if (step_en) begin
         state_ff     <= state_in;
         countdown_ff <= countdown_in;
         polls_ff     <= polls_in;
         attempts_ff  <= attempts_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      countdown_in = countdown_ff;
      polls_in     = polls_ff;
      attempts_in  = attempts_ff;
      action       = ACT_NONE;
      rcode        = RC_NONE;
      supd         = SU_NONE;
      if (item.reload_pending) begin
         action   = ACT_RELOAD;
         state_in = S_CLOSE;
      end else begin
         unique case (state_ff)
            S_CLOSE: begin
               action       = ACT_CLOSE;
               countdown_in = cfg.close_wait;
               state_in     = S_CLOSE_WAIT;
            end
            S_CLOSE_WAIT: begin
               if (item.socket_is_open) begin
                  // With the countdown already spent no second is waited.
                  if (countdown_ff != '0) begin
                     countdown_in = countdown_ff - 1'b1;
                     action       = ACT_WAIT;
                  end
                  state_in = S_CLOSE_CHECK;
               end else begin
                  attempts_in = cfg.open_attempts;
                  state_in    = S_OPEN;
               end
            end
            S_CLOSE_CHECK: begin
               if (countdown_ff != '0) begin
                  state_in = S_CLOSE_WAIT;
               end else begin
                  action   = ACT_OFF;
                  state_in = S_CLOSE;
               end
            end
            S_OPEN: begin
               action       = ACT_OPEN;
               countdown_in = cfg.poll_interval;
               polls_in     = cfg.poll_count;
               state_in     = S_POLL;
            end
            S_POLL: begin
               if (item.socket_is_open) begin
                  action   = ACT_STANDBY;
                  state_in = S_CLOSE;
               end else if (countdown_ff != '0) begin
                  countdown_in = countdown_ff - 1'b1;
                  action       = ACT_WAIT;
               end else begin
                  action   = ACT_EVAL;
                  state_in = S_CHECK;
                  // ERROR text takes precedence over CONNECT text.
                  if (item.error_seen) begin
                     rcode = RC_ERROR;
                     supd  = SU_CLOSED;
                  end else if (item.connect_seen) begin
                     rcode = RC_CONNECTED;
                     supd  = SU_OPEN;
                  end
               end
            end
            S_CHECK: begin
               if (item.socket_is_open) begin
                  action   = ACT_STANDBY;
                  state_in = S_CLOSE;
               end else if (item.response_was_error) begin
                  attempts_in = dec_sat(attempts_ff);
                  state_in    = S_RETRY;
               end else begin
                  polls_in = dec_sat(polls_ff);
                  state_in = S_NEXT_POLL;
               end
            end
            S_NEXT_POLL: begin
               if (polls_ff != '0) begin
                  countdown_in = cfg.poll_interval;
                  state_in     = S_POLL;
               end else begin
                  attempts_in = dec_sat(attempts_ff);
                  state_in    = S_RETRY;
               end
            end
            S_RETRY: begin
               if (attempts_ff != '0) begin
                  state_in = S_OPEN;
               end else begin
                  action   = ACT_OFF;
                  state_in = S_CLOSE;
               end
            end
            default: begin
               state_in = S_CLOSE;
            end
         endcase
      end
   end

   always_comb begin
      result.action        = action;
      result.next_substate = state_in;
      result.response_code = rcode;
      result.socket_update = supd;
   end

endmodule

// File: src/socket_open_retry_fsm_core.sv
// Top level of the socket open retry sequencer: stream channels, input and
// result registers. Depends on sorf_pkg, sorf_csr, sorf_step and the defines header.
//
// Usage: each transfer on the req_ channel is one step of a modem socket-opening
// sequence, carrying the current status flags. Every step produces exactly one
// transfer on the rsp_ channel with the action to take, the substate after the
// step and, for an evaluate action, the decoded modem response and socket update.
// An accepted request lands in the input register; when the step advances, the
// step logic writes the result register, from which the response is valid,
// while it updates the sequencer state. While the receiver takes each result,
// one request is accepted every cycle, so sustained throughput is one step per
// cycle; the sequencer state in sorf_step updates once per step.
// When the receiver stalls, the result register holds its transfer; the input
// register can still take one more request, after which req_tready drops until
// the result is taken. Synchronous reset clears the substate and all counters
// to zero, empties both registers and loads the configuration registers with
// their defaults (30, 5, 6, 3). The user must write configuration through the
// csr_ port only while no step is in flight; the block itself does not enforce this.
`include "socket_open_retry_fsm_core_defines.svh"
module socket_open_retry_fsm_core (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] socket_is_open, [1] response_was_error, [2] connect_seen,
   // [3] error_seen, [4] reload_pending, [7:5] zero
   input  logic [7:0]  req_tdata,
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] action, [5:3] next_substate, [7:6] response_code,
   // [9:8] socket_update, [15:10] zero
   output logic [15:0] rsp_tdata,
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import sorf_pkg::*;

   cfg_type    cfg;
   item_type   in_ff, in_in;
   logic       in_valid_ff, in_valid_in;
   result_type out_ff, step_result;
   logic       out_valid_ff, out_valid_in;
   logic       req_take;
   logic       advance;

   // A step advances whenever the input register holds an item and the result
   // register is empty or its transfer completes this cycle.
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_take   = req_tvalid & req_tready;

   always_comb begin
      in_in.socket_is_open     = req_tdata[0];
      in_in.response_was_error = req_tdata[1];
      in_in.connect_seen       = req_tdata[2];
      in_in.error_seen         = req_tdata[3];
      in_in.reload_pending     = req_tdata[4];
      in_valid_in              = req_take | (in_valid_ff & ~advance);
      out_valid_in             = advance | (out_valid_ff & ~rsp_tready);
   end

   sorf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sorf_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers load only on their own transfers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= in_in;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.socket_update, out_ff.response_code,
                        out_ff.next_substate, out_ff.action};

   // A step that advances always leaves a result waiting.
   `SORF_ASSERT_NEXT(a_advance_fills, clock, reset, advance, out_valid_ff)
   // Only an evaluate step carries a response code or a socket update.
   `SORF_ASSERT_IMPL(a_eval_only_codes, clock, reset,
                     out_valid_ff && (out_ff.action != ACT_EVAL),
                     (out_ff.response_code == RC_NONE) && (out_ff.socket_update == SU_NONE))
   // A reload request aborts the sequence back to the first substate.
   `SORF_ASSERT_NEXT(a_reload_abort, clock, reset, advance && in_ff.reload_pending,
                     (out_ff.action == ACT_RELOAD) && (out_ff.next_substate == S_CLOSE))

endmodule
